/* rtl/core/arpt_pkg.sv */
// Shared constants, codes and controller/datapath types for the peer tracker.
`default_nettype none

package arpt_pkg;

    localparam int PEER_SLOTS  = 8;
    localparam int SLOT_W      = $clog2(PEER_SLOTS);
    localparam int COUNT_W     = $clog2(PEER_SLOTS + 1);

    localparam int ADDR_W      = 8;
    localparam int ROUND_W     = 8;
    localparam int TRIES_W     = 8;
    localparam int CMD_W       = 3;
    localparam int CODE_W      = 4;
    localparam int ACT_W       = 3;
    localparam int HEAD_W      = 2;
    localparam int PEERS_OUT_W = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 16;

    localparam logic [ROUND_W-1:0] ROUND_LIMIT     = 8'd3;
    localparam logic [TRIES_W-1:0] MAX_TRIES_RESET = 8'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_SELF_ADDR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIES = 1'b1;

    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MSG    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_START  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PAUSE  = 3'd4;

    localparam logic [CODE_W-1:0] MSG_ACK     = 4'h0;
    localparam logic [CODE_W-1:0] MSG_PING    = 4'h1;
    localparam logic [CODE_W-1:0] MSG_WAKE    = 4'h2;
    localparam logic [CODE_W-1:0] MSG_CAP_LO  = 4'h3;
    localparam logic [CODE_W-1:0] MSG_CAP_HI  = 4'h6;
    localparam logic [CODE_W-1:0] MSG_REL_LO  = 4'h7;
    localparam logic [CODE_W-1:0] MSG_REL_HI  = 4'hA;
    localparam logic [CODE_W-1:0] MSG_ERASE   = 4'hB;
    localparam logic [CODE_W-1:0] MSG_REBOOT  = 4'hC;

    localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_WAKE    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_CAPTURE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_ERASE   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_REBOOT  = 3'd5;

    typedef struct packed {
        logic              load;
        logic              exec;
        logic              reg_step;
        logic              age_step;
        logic              cnt_step;
        logic              first;
        logic              last;
        logic [SLOT_W-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic go_msg;
        logic go_age;
    } t_dp_stat;

endpackage

`default_nettype wire

/* rtl/core/arpt_ctrl.sv */
// Sequencer that walks the peer table for each word and hands off the result.
`default_nettype none

module arpt_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_valid,
    input  wire logic              i_out_free,
    input  wire arpt_pkg::t_dp_stat i_stat,
    output arpt_pkg::t_dp_cmd      o_cmd,
    output logic                   o_ready,
    output logic                   o_out_load
);
    import arpt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_REG   = 6'b000100,
        S_AGE   = 6'b001000,
        S_COUNT = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic              last;

    assign last = (r_idx == SLOT_W'(PEER_SLOTS - 1));

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        o_cmd        = '0;
        o_cmd.idx    = r_idx;
        o_cmd.first  = (r_idx == '0);
        o_cmd.last   = last;
        o_ready      = 1'b0;
        o_out_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_s_valid;
                if (i_s_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_idx      = '0;
                if (i_stat.go_msg) begin
                    n_state = S_REG;
                end else if (i_stat.go_age) begin
                    n_state = S_AGE;
                end else begin
                    n_state = S_COUNT;
                end
            end
            S_REG: begin
                o_cmd.reg_step = 1'b1;
                if (last) begin
                    n_idx   = '0;
                    n_state = S_COUNT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_AGE: begin
                o_cmd.age_step = 1'b1;
                if (last) begin
                    n_idx   = '0;
                    n_state = S_COUNT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_COUNT: begin
                o_cmd.cnt_step = 1'b1;
                if (last) begin
                    n_idx   = '0;
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_idx   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/arpt_dpath.sv */
// Peer table, flags, attempt counter and the per-entry update logic.
`default_nettype none

module arpt_dpath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire arpt_pkg::t_dp_cmd                   i_cmd,
    output arpt_pkg::t_dp_stat                       o_stat,
    input  wire logic                                i_cfg_we,
    input  wire logic [arpt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [arpt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic [arpt_pkg::CMD_W-1:0]          i_command,
    input  wire logic                                i_changed,
    input  wire logic [arpt_pkg::ADDR_W-1:0]         i_sender,
    input  wire logic [arpt_pkg::CODE_W-1:0]         i_code,
    input  wire logic                                i_pflag,
    output logic                                     o_sent,
    output logic [arpt_pkg::ACT_W-1:0]               o_action,
    output logic [arpt_pkg::HEAD_W-1:0]              o_head,
    output logic                                     o_pending,
    output logic [arpt_pkg::PEERS_OUT_W-1:0]         o_peers
);
    import arpt_pkg::*;

    logic [ADDR_W-1:0]  r_addr   [PEER_SLOTS];
    logic [ADDR_W-1:0]  n_addr   [PEER_SLOTS];
    logic [ROUND_W-1:0] r_rounds [PEER_SLOTS];
    logic [ROUND_W-1:0] n_rounds [PEER_SLOTS];
    logic [PEER_SLOTS-1:0] r_ack, n_ack;

    logic               r_pending, n_pending;
    logic [TRIES_W-1:0] r_attempts, n_attempts;
    logic               r_paused, n_paused;
    logic               r_started, n_started;
    logic [ADDR_W-1:0]  r_self;
    logic [TRIES_W-1:0] r_max;

    logic [CMD_W-1:0]   r_cmd, n_cmd;
    logic               r_changed, n_changed;
    logic [ADDR_W-1:0]  r_sender, n_sender;
    logic [CODE_W-1:0]  r_code, n_code;
    logic               r_pflag, n_pflag;

    logic               r_sent, n_sent;
    logic [ACT_W-1:0]   r_act, n_act;
    logic [HEAD_W-1:0]  r_head, n_head;
    logic               r_found, n_found;
    logic               r_all, n_all;
    logic [COUNT_W-1:0] r_cnt, n_cnt;

    logic [TRIES_W-1:0] att_inc;
    logic               tick_pend;
    logic               tick_send;
    logic               tick_age;
    logic [ADDR_W-1:0]  cur_addr;
    logic [ROUND_W-1:0] cur_rounds;
    logic               cur_ack;
    logic               hit;
    logic [ADDR_W-1:0]  eff_addr;
    logic               ack_new;
    logic               all_step;
    logic [ROUND_W-1:0] aged;
    logic               remove;

    assign att_inc    = r_attempts + 8'd1;
    assign tick_pend  = (r_addr[0] == '0) ? 1'b0 : r_pending;
    assign tick_send  = tick_pend && !r_paused;
    assign tick_age   = tick_send && (att_inc > r_max);
    assign cur_addr   = r_addr[i_cmd.idx];
    assign cur_rounds = r_rounds[i_cmd.idx];
    assign cur_ack    = r_ack[i_cmd.idx];

    assign hit      = !(r_found && !i_cmd.first)
                      && ((cur_addr == r_sender) || (cur_addr == '0));
    assign eff_addr = hit ? r_sender : cur_addr;
    assign ack_new  = cur_ack || ((r_code == MSG_ACK) && (eff_addr == r_sender));
    assign all_step = (i_cmd.first ? 1'b1 : r_all) && (ack_new || (eff_addr == '0));
    assign aged     = cur_ack ? cur_rounds : (cur_rounds - 8'd1);
    assign remove   = (cur_addr != '0) && (aged == '0);

    assign o_stat.go_msg = r_started && (r_cmd == CMD_MSG);
    assign o_stat.go_age = r_started && (r_cmd == CMD_TICK) && tick_age;

    always_comb begin
        n_addr     = r_addr;
        n_rounds   = r_rounds;
        n_ack      = r_ack;
        n_pending  = r_pending;
        n_attempts = r_attempts;
        n_paused   = r_paused;
        n_started  = r_started;
        n_cmd      = r_cmd;
        n_changed  = r_changed;
        n_sender   = r_sender;
        n_code     = r_code;
        n_pflag    = r_pflag;
        n_sent     = r_sent;
        n_act      = r_act;
        n_head     = r_head;
        n_found    = r_found;
        n_all      = r_all;
        n_cnt      = r_cnt;

        if (i_cmd.load) begin
            n_cmd     = i_command;
            n_changed = i_changed;
            n_sender  = i_sender;
            n_code    = i_code;
            n_pflag   = i_pflag;
        end

        if (i_cmd.exec) begin
            n_sent = 1'b0;
            n_act  = ACT_NONE;
            n_head = '0;
            case (r_cmd)
                CMD_TICK: begin
                    if (r_started) begin
                        if (tick_send) begin
                            n_sent = 1'b1;
                            if (tick_age) begin
                                n_attempts = '0;
                                n_pending  = 1'b0;
                            end else begin
                                n_attempts = att_inc;
                                n_pending  = tick_pend;
                            end
                        end else begin
                            n_pending = tick_pend || r_changed;
                        end
                    end
                end
                CMD_MSG: begin
                    if (r_started) begin
                        if (r_code == MSG_PING) begin
                            n_pending  = 1'b1;
                            n_attempts = '0;
                        end else if (r_code == MSG_WAKE) begin
                            n_act = ACT_WAKE;
                        end else if (r_code inside {[MSG_CAP_LO:MSG_CAP_HI]}) begin
                            n_act  = ACT_CAPTURE;
                            n_head = HEAD_W'(r_code - MSG_CAP_LO);
                        end else if (r_code inside {[MSG_REL_LO:MSG_REL_HI]}) begin
                            n_act  = ACT_RELEASE;
                            n_head = HEAD_W'(r_code - MSG_REL_LO);
                        end else if (r_code == MSG_ERASE) begin
                            n_act = ACT_ERASE;
                        end else if (r_code == MSG_REBOOT) begin
                            n_act = ACT_REBOOT;
                        end
                    end
                end
                CMD_UPDATE: begin
                    n_pending  = 1'b1;
                    n_attempts = '0;
                end
                CMD_START: begin
                    n_attempts  = '0;
                    n_addr[0]   = r_self;
                    n_rounds[0] = ROUND_LIMIT;
                    n_ack[0]    = 1'b0;
                    n_started   = 1'b1;
                end
                CMD_PAUSE: begin
                    n_paused = r_pflag;
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.reg_step) begin
            if (hit) begin
                n_addr[i_cmd.idx]   = r_sender;
                n_rounds[i_cmd.idx] = ROUND_LIMIT;
            end
            n_ack[i_cmd.idx] = ack_new;
            n_found          = (r_found && !i_cmd.first) || hit;
            n_all            = all_step;
            if (i_cmd.last && (r_code == MSG_ACK) && all_step) begin
                n_pending  = 1'b0;
                n_attempts = '0;
            end
        end

        if (i_cmd.age_step) begin
            if (remove) begin
                for (int x = 0; x < PEER_SLOTS - 1; x++) begin
                    if (SLOT_W'(x) >= i_cmd.idx) begin
                        n_addr[x]   = r_addr[x + 1];
                        n_rounds[x] = r_rounds[x + 1];
                        n_ack[x]    = r_ack[x + 1];
                    end
                end
                n_addr[PEER_SLOTS - 1]   = '0;
                n_rounds[PEER_SLOTS - 1] = '0;
                n_ack[PEER_SLOTS - 1]    = 1'b0;
            end else begin
                n_rounds[i_cmd.idx] = aged;
            end
        end

        if (i_cmd.cnt_step) begin
            n_cnt = (i_cmd.first ? '0 : r_cnt) + COUNT_W'(cur_addr != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PEER_SLOTS; k++) begin
                r_addr[k]   <= '0;
                r_rounds[k] <= '0;
            end
            r_ack      <= '0;
            r_pending  <= 1'b0;
            r_attempts <= '0;
            r_paused   <= 1'b0;
            r_started  <= 1'b0;
            r_self     <= '0;
            r_max      <= MAX_TRIES_RESET;
            r_found    <= 1'b0;
            r_all      <= 1'b1;
            r_cnt      <= '0;
        end else begin
            r_addr     <= n_addr;
            r_rounds   <= n_rounds;
            r_ack      <= n_ack;
            r_pending  <= n_pending;
            r_attempts <= n_attempts;
            r_paused   <= n_paused;
            r_started  <= n_started;
            r_found    <= n_found;
            r_all      <= n_all;
            r_cnt      <= n_cnt;
            if (i_cfg_we && (i_cfg_idx == CFG_SELF_ADDR)) begin
                r_self <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == CFG_MAX_TRIES)) begin
                r_max <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_changed <= n_changed;
        r_sender  <= n_sender;
        r_code    <= n_code;
        r_pflag   <= n_pflag;
        r_sent    <= n_sent;
        r_act     <= n_act;
        r_head    <= n_head;
    end

    assign o_sent    = r_sent;
    assign o_action  = r_act;
    assign o_head    = r_head;
    assign o_pending = r_pending;
    assign o_peers   = PEERS_OUT_W'(r_cnt);

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_cmd.cnt_step && i_cmd.last |=> (r_cnt <= COUNT_W'(PEER_SLOTS)))
        else $error("peer count exceeds the table size");

    a_start_seeds_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_cmd.exec && (r_cmd == CMD_START)
        |=> (r_addr[0] == $past(r_self)) && r_started)
        else $error("start did not seed entry zero with the own address");

endmodule

`default_nettype wire

/* rtl/core/ack_retry_peer_tracker_core.sv */
// Top level of the peer acknowledgement and retry tracker.
//
// One input word carries a command in s_axis_tuser (tick, received message,
// local update request, start, set pause) and its operands in s_axis_tdata.
// Every accepted word yields exactly one result word on the master side.
// The own address and the attempt limit are set through the write port.
// A word is taken only while the sequencer is idle. Each word passes a decode
// state and then a counting walk over all PEER_SLOTS entries, one entry a cycle;
// a message after the first start and a tick that ends a round first walk the
// table once more. The result is loaded into the output register once the walk
// ends and the register is free, and only then is the next word taken.
// The result is held in an output register, so a new word is accepted while a
// result still waits; if the receiver stalls, the next result waits in the
// sequencer and no further word is taken until the register frees up.
// Synchronous reset empties the table, clears all flags and the attempt count,
// restores the attempt limit to ten and drops any result not yet taken.
`default_nettype none

module ack_retry_peer_tracker_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // [0] inputs_changed, [8:1] sender_address, [12:9] message_code,
    // [13] pause_flag, [15:14] zero
    input  wire logic [arpt_pkg::S_TDATA_W-1:0]        s_axis_tdata,
    // [2:0] command
    input  wire logic [arpt_pkg::CMD_W-1:0]            s_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // [0] send_report, [3:1] action, [5:4] head_index, [6] report_pending,
    // [10:7] peers_in_use, [15:11] zero
    output logic [arpt_pkg::M_TDATA_W-1:0]             m_axis_tdata,
    input  wire logic                                  i_cfg_we,
    input  wire logic [arpt_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [arpt_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import arpt_pkg::*;

    t_dp_cmd                dp_cmd;
    t_dp_stat               dp_stat;
    logic                   out_load;
    logic                   out_free;
    logic                   sent;
    logic [ACT_W-1:0]       action;
    logic [HEAD_W-1:0]      head;
    logic                   pending;
    logic [PEERS_OUT_W-1:0] peers;
    logic                   r_valid, n_valid;
    logic [M_TDATA_W-1:0]   r_tdata;

    assign out_free = !r_valid || m_axis_tready;

    arpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (s_axis_tvalid),
        .i_out_free (out_free),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_ready    (s_axis_tready),
        .o_out_load (out_load)
    );

    arpt_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_command  (s_axis_tuser),
        .i_changed  (s_axis_tdata[0]),
        .i_sender   (s_axis_tdata[8:1]),
        .i_code     (s_axis_tdata[12:9]),
        .i_pflag    (s_axis_tdata[13]),
        .o_sent     (sent),
        .o_action   (action),
        .o_head     (head),
        .o_pending  (pending),
        .o_peers    (peers)
    );

    always_comb begin
        n_valid = r_valid;
        if (out_load) begin
            n_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_tdata <= {5'b0, peers, pending, head, action, sent};
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_tdata;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("a second word was accepted while the first is in progress");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("a result word appeared while the sequencer was idle");

endmodule

`default_nettype wire

/* tb/peer_report_checker.sv */
// Checker that predicts the peer tracker's result words and compares them with the output.
module peer_report_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [arpt_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic [arpt_pkg::CMD_W-1:0]      s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [arpt_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [arpt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [arpt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_mismatches,
    output int                              o_outstanding
);
    import arpt_pkg::*;

    logic [ADDR_W-1:0]    peer_addr [PEER_SLOTS];
    logic [ROUND_W-1:0]   rounds    [PEER_SLOTS];
    logic                 acked     [PEER_SLOTS];
    logic                 pending;
    logic                 paused;
    logic                 started;
    logic [TRIES_W-1:0]   attempts;
    logic [ADDR_W-1:0]    self_addr;
    logic [TRIES_W-1:0]   max_tries;
    logic [M_TDATA_W-1:0] report_q [$];

    task automatic drop_peer(input int idx);
        for (int x = idx; x + 1 < PEER_SLOTS; x++) begin
            peer_addr[x] = peer_addr[x+1];
            rounds[x]    = rounds[x+1];
            acked[x]     = acked[x+1];
        end
        peer_addr[PEER_SLOTS-1] = '0;
        rounds[PEER_SLOTS-1]    = '0;
        acked[PEER_SLOTS-1]     = 1'b0;
    endtask

    task automatic close_round();
        for (int i = 0; i < PEER_SLOTS; i++) begin
            if (!acked[i]) begin
                rounds[i] = rounds[i] - 1'b1;
            end
            if (peer_addr[i] != '0 && rounds[i] == '0) begin
                drop_peer(i);
            end
        end
    endtask

    task automatic track_step(input logic [CMD_W-1:0] cmd, input logic [S_TDATA_W-1:0] word,
                              output logic [M_TDATA_W-1:0] rep);
        logic                   changed;
        logic                   pflag;
        logic                   sent;
        logic                   all_acked;
        logic                   placed;
        logic [ADDR_W-1:0]      from;
        logic [CODE_W-1:0]      code;
        logic [ACT_W-1:0]       act;
        logic [HEAD_W-1:0]      head;
        logic [PEERS_OUT_W-1:0] peers;
        changed = word[0];
        from    = word[8:1];
        code    = word[12:9];
        pflag   = word[13];
        sent    = 1'b0;
        act     = ACT_NONE;
        head    = '0;
        case (cmd)
            CMD_TICK: begin
                if (started) begin
                    if (peer_addr[0] == '0) begin
                        pending = 1'b0;
                    end
                    if (pending && !paused) begin
                        sent     = 1'b1;
                        attempts = attempts + 1'b1;
                        if (attempts > max_tries) begin
                            attempts = '0;
                            pending  = 1'b0;
                            close_round();
                        end
                    end else if (changed) begin
                        pending = 1'b1;
                    end
                end
            end
            CMD_MSG: begin
                if (started) begin
                    placed = 1'b0;
                    for (int i = 0; i < PEER_SLOTS; i++) begin
                        if (!placed && (peer_addr[i] == from || peer_addr[i] == '0)) begin
                            peer_addr[i] = from;
                            rounds[i]    = ROUND_LIMIT;
                            placed       = 1'b1;
                        end
                    end
                    if (code == MSG_ACK) begin
                        all_acked = 1'b1;
                        for (int i = 0; i < PEER_SLOTS; i++) begin
                            if (peer_addr[i] == from) begin
                                acked[i] = 1'b1;
                            end
                            if (!acked[i] && peer_addr[i] != '0) begin
                                all_acked = 1'b0;
                            end
                        end
                        if (all_acked) begin
                            pending  = 1'b0;
                            attempts = '0;
                        end
                    end else if (code == MSG_PING) begin
                        pending  = 1'b1;
                        attempts = '0;
                    end else if (code == MSG_WAKE) begin
                        act = ACT_WAKE;
                    end else if (code >= MSG_CAP_LO && code <= MSG_CAP_HI) begin
                        act  = ACT_CAPTURE;
                        head = HEAD_W'(code - MSG_CAP_LO);
                    end else if (code >= MSG_REL_LO && code <= MSG_REL_HI) begin
                        act  = ACT_RELEASE;
                        head = HEAD_W'(code - MSG_REL_LO);
                    end else if (code == MSG_ERASE) begin
                        act = ACT_ERASE;
                    end else if (code == MSG_REBOOT) begin
                        act = ACT_REBOOT;
                    end
                end
            end
            CMD_UPDATE: begin
                pending  = 1'b1;
                attempts = '0;
            end
            CMD_START: begin
                attempts     = '0;
                peer_addr[0] = self_addr;
                rounds[0]    = ROUND_LIMIT;
                acked[0]     = 1'b0;
                started      = 1'b1;
            end
            CMD_PAUSE: begin
                paused = pflag;
            end
            default: begin
            end
        endcase
        peers = '0;
        for (int i = 0; i < PEER_SLOTS; i++) begin
            if (peer_addr[i] != '0) begin
                peers = peers + 1'b1;
            end
        end
        rep = {5'b0, peers, pending, head, act, sent};
    endtask

    task automatic flag_mismatch(input logic [M_TDATA_W-1:0] want, input logic known);
        if (o_mismatches < 10) begin
            if (known) begin
                $display("mismatch at %0t: expected send=%0d act=%0d head=%0d pend=%0d peers=%0d",
                         $realtime, want[0], want[3:1], want[5:4], want[6], want[10:7]);
            end else begin
                $display("mismatch at %0t: result word with no expected word", $realtime);
            end
            $display("    got send=%0d act=%0d head=%0d pend=%0d peers=%0d (word %h)",
                     m_axis_tdata[0], m_axis_tdata[3:1], m_axis_tdata[5:4],
                     m_axis_tdata[6], m_axis_tdata[10:7], m_axis_tdata);
        end
        o_mismatches = o_mismatches + 1;
    endtask

    always @(posedge i_clk) begin : watch
        logic [M_TDATA_W-1:0] want;
        logic [M_TDATA_W-1:0] rep;
        if (!i_rst_n) begin
            for (int i = 0; i < PEER_SLOTS; i++) begin
                peer_addr[i] = '0;
                rounds[i]    = '0;
                acked[i]     = 1'b0;
            end
            pending   = 1'b0;
            paused    = 1'b0;
            started   = 1'b0;
            attempts  = '0;
            self_addr = '0;
            max_tries = MAX_TRIES_RESET;
            report_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (report_q.size() == 0) begin
                    flag_mismatch('0, 1'b0);
                end else begin
                    want = report_q.pop_front();
                    if (want !== m_axis_tdata) begin
                        flag_mismatch(want, 1'b1);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SELF_ADDR: self_addr = i_cfg_data;
                    CFG_MAX_TRIES: max_tries = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                track_step(s_axis_tuser, s_axis_tdata, rep);
                report_q.push_back(rep);
            end
        end
        o_outstanding = report_q.size();
    end

endmodule

/* tb/tb_ack_retry_peer_tracker_core.sv */
// Testbench top that drives directed and random words into the peer tracker and gives the verdict.
module tb_ack_retry_peer_tracker_core;
    import arpt_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic [CMD_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    mismatches;
    int                    outstanding;
    logic                  quick;
    logic [ADDR_W-1:0]     pool [6];

    ack_retry_peer_tracker_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    peer_report_checker report_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [S_TDATA_W-1:0] pack_in(input logic changed,
                                                     input logic [ADDR_W-1:0] from,
                                                     input logic [CODE_W-1:0] code,
                                                     input logic pflag);
        return {2'b00, pflag, code, from, changed};
    endfunction

    task automatic push_word(input logic [CMD_W-1:0] cmd, input logic [S_TDATA_W-1:0] word);
        int gap;
        gap = quick ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tuser  = cmd;
        s_axis_tdata  = word;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic new_phase(input logic [ADDR_W-1:0] self, input logic [TRIES_W-1:0] tries);
        settle();
        cfg_write(CFG_SELF_ADDR, self);
        cfg_write(CFG_MAX_TRIES, tries);
        for (int i = 0; i < 6; i++) begin
            pool[i] = ADDR_W'($urandom_range(1, 255));
        end
        pool[5] = self;
    endtask

    function automatic logic [ADDR_W-1:0] pick_peer();
        if ($urandom_range(0, 99) < 3) begin
            return '0;
        end
        return pool[$urandom_range(0, 5)];
    endfunction

    task automatic run_random(input int n_items);
        int done;
        int kind;
        int len;
        int r;
        logic [S_TDATA_W-1:0] noise;
        logic [CODE_W-1:0] code;
        done = 0;
        push_word(CMD_START, S_TDATA_W'($urandom_range(0, 16'h3FFF)));
        while (done < n_items) begin
            quick = ($urandom_range(0, 7) == 0);
            kind  = $urandom_range(0, 99);
            noise = S_TDATA_W'($urandom_range(0, 16'h3FFF));
            if (kind < 35) begin
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++) begin
                    noise    = S_TDATA_W'($urandom_range(0, 16'h3FFF));
                    noise[0] = ($urandom_range(0, 3) == 0);
                    push_word(CMD_TICK, noise);
                end
                done += len;
            end else if (kind < 75) begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < 40) begin
                        code = MSG_ACK;
                    end else if (r < 65) begin
                        code = MSG_PING;
                    end else begin
                        code = CODE_W'($urandom_range(2, 15));
                    end
                    push_word(CMD_MSG, pack_in(1'($urandom_range(0, 1)), pick_peer(), code,
                                               1'($urandom_range(0, 1))));
                end
                done += len;
            end else begin
                if (kind < 83) begin
                    push_word(CMD_UPDATE, noise);
                end else if (kind < 90) begin
                    noise[13] = ($urandom_range(0, 2) == 0);
                    push_word(CMD_PAUSE, noise);
                end else if (kind < 93) begin
                    push_word(CMD_START, noise);
                end else if (kind < 96) begin
                    push_word(CMD_W'($urandom_range(5, 7)), noise);
                end else begin
                    push_word(CMD_MSG, noise);
                end
                done += 1;
            end
        end
    endtask

    initial begin : drain_side
        int stall;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = quick ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            @(negedge i_clk);
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_TICK;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_SELF_ADDR;
        i_cfg_data    = '0;
        quick         = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Words before the first start only report status; update and pause always work.
        push_word(CMD_TICK, pack_in(1'b1, 8'h00, MSG_ACK, 1'b0));
        push_word(CMD_MSG, pack_in(1'b0, 8'h11, MSG_PING, 1'b0));
        push_word(CMD_UPDATE, '0);
        push_word(CMD_PAUSE, pack_in(1'b0, 8'h00, MSG_ACK, 1'b1));

        new_phase(8'hFF, 8'd1);
        push_word(CMD_START, '0);
        push_word(CMD_TICK, pack_in(1'b1, 8'h00, MSG_ACK, 1'b0));
        push_word(CMD_PAUSE, pack_in(1'b0, 8'h00, MSG_ACK, 1'b0));
        push_word(CMD_MSG, pack_in(1'b0, 8'h00, MSG_ACK, 1'b0));
        push_word(CMD_MSG, pack_in(1'b0, 8'h22, MSG_WAKE, 1'b0));
        push_word(CMD_MSG, pack_in(1'b0, 8'h33, MSG_CAP_LO, 1'b0));
        push_word(CMD_MSG, pack_in(1'b0, 8'h44, MSG_CAP_HI, 1'b0));
        push_word(CMD_MSG, pack_in(1'b0, 8'h55, MSG_REL_LO, 1'b0));
        push_word(CMD_MSG, pack_in(1'b0, 8'h66, MSG_REL_HI, 1'b0));
        push_word(CMD_MSG, pack_in(1'b0, 8'h77, MSG_ERASE, 1'b0));
        push_word(CMD_MSG, pack_in(1'b0, 8'h88, MSG_REBOOT, 1'b0));
        push_word(CMD_MSG, pack_in(1'b1, 8'h99, 4'hF, 1'b1));
        push_word(CMD_TICK, pack_in(1'b0, 8'h00, MSG_ACK, 1'b0));
        push_word(CMD_TICK, pack_in(1'b0, 8'h00, MSG_ACK, 1'b0));
        push_word(CMD_MSG, pack_in(1'b0, 8'hFF, MSG_ACK, 1'b0));
        push_word(3'd5, 16'h3FFF);
        push_word(3'd7, 16'h2AAA);
        push_word(CMD_START, '0);
        push_word(CMD_MSG, pack_in(1'b0, 8'h01, 4'hD, 1'b0));
        push_word(CMD_TICK, pack_in(1'b0, 8'h00, MSG_ACK, 1'b0));

        new_phase(8'h01, 8'd10);
        run_random(290);
        new_phase(8'h00, 8'd3);
        run_random(290);
        new_phase(8'hA5, 8'd255);
        run_random(290);
        new_phase(8'h7E, 8'd1);
        run_random(290);
        new_phase(8'hFF, 8'd0);
        run_random(290);
        new_phase(8'h3C, 8'd10);
        run_random(290);

        settle();
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/arpt_pkg.sv
rtl/core/arpt_ctrl.sv
rtl/core/arpt_dpath.sv
rtl/core/ack_retry_peer_tracker_core.sv
tb/peer_report_checker.sv
tb/tb_ack_retry_peer_tracker_core.sv
